@@ hdl/scanline_illumination_gradient_unit_defines.svh @@
// Assertion macros shared by the scanline illumination gradient unit.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef SCANLINE_ILLUMINATION_GRADIENT_UNIT_DEFINES_SVH
`define SCANLINE_ILLUMINATION_GRADIENT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIGU_ASSERT_SAME(label, ante, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (conseq)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIGU_ASSERT_NEXT(label, ante, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (conseq)) \
    else $error(msg);

`endif

@@ hdl/sigu_pkg.sv @@
package sigu_pkg;

  // Field widths of the channels.
  localparam int PIXEL_W  = 8;
  localparam int THRESH_W = 9;
  localparam int VALUE_W  = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd10;
  // Pixel count at which the filter window is full.
  localparam logic [2:0] SEEN_FULL = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_FLUSH1,
    ST_FLUSH2,
    ST_LINE_DIV,
    ST_LINE_WAIT,
    ST_ACCUM,
    ST_IMAGE_DIV,
    ST_IMAGE_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_STEP,
    OP_FLUSH1,
    OP_FLUSH2,
    OP_LINE_DIV,
    OP_ACCUM,
    OP_IMAGE_DIV,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic load;
    logic cfg_write;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic eol;
    logic div_busy;
  } status_t;

  // Median of five by eliminating the two smallest candidates.
  function automatic logic [PIXEL_W-1:0] median5(
    input logic [PIXEL_W-1:0] a_in, input logic [PIXEL_W-1:0] b_in,
    input logic [PIXEL_W-1:0] c_in, input logic [PIXEL_W-1:0] d_in,
    input logic [PIXEL_W-1:0] e_in);
    logic [PIXEL_W-1:0] a, b, c, d, t;
    a = a_in;
    b = b_in;
    c = c_in;
    d = d_in;
    if (b < a) begin t = a; a = b; b = t; end
    if (d < c) begin t = c; c = d; d = t; end
    // The smaller of the two pair minima lies below the median.
    if (c < a) begin
      t = a; a = c; c = t;
      t = b; b = d; d = t;
    end
    a = e_in;
    if (b < a) begin t = a; a = b; b = t; end
    if (c < a) begin
      t = a; a = c; c = t;
      t = b; b = d; d = t;
    end
    // The median is the smallest of the three that remain.
    median5 = (b < c) ? b : c;
  endfunction

endpackage

@@ hdl/sigu_divider.sv @@
module sigu_divider
  import sigu_pkg::*;
#(
  parameter int DIV_W = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_W-1:0]   hi,
  input  logic [VALUE_W-1:0] lo,
  input  logic [DIV_W-1:0]   divisor,
  output logic               busy,
  output logic [VALUE_W-1:0] quotient
);

  localparam int STEP_W = $clog2(VALUE_W);

  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   dvs;
  logic [VALUE_W-1:0] quo;
  logic [STEP_W-1:0]  step;
  logic [DIV_W:0]     trial;
  logic [DIV_W:0]     trial_sub;
  logic               fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial     = {rem, quo[VALUE_W-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = (trial >= {1'b0, dvs});
  end

  // Control: step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(VALUE_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder and quotient; the high part of the dividend starts as remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= hi;
      quo <= lo;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[VALUE_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ hdl/sigu_datapath.sv @@
module sigu_datapath
  import sigu_pkg::*;
#(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int MAX_SCAN_LINES  = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [THRESH_W-1:0] diff_threshold,
  input  logic [PIXEL_W-1:0]  pixel,
  input  logic                last_in_line,
  input  logic                last_in_image,
  output logic [VALUE_W-1:0]  line_value,
  output logic                line_empty,
  output logic [VALUE_W-1:0]  image_value,
  output logic                image_done
);

  localparam int CNT_W  = $clog2(MAX_LINE_PIXELS);
  localparam int SUM_W  = PIXEL_W + CNT_W + 1;
  localparam int MAG_W  = SUM_W - 1;
  localparam int LCNT_W = $clog2(MAX_SCAN_LINES + 1);
  localparam int LT_W   = VALUE_W + LCNT_W;
  localparam int DIV_W  = (CNT_W > LCNT_W) ? CNT_W : LCNT_W;

  logic [THRESH_W-1:0]    thr;
  logic [PIXEL_W-1:0]     pix_in;
  logic                   eol_in;
  logic                   eoi_in;
  logic [PIXEL_W-1:0]     window [4];
  logic [2:0]             seen;
  logic [PIXEL_W-1:0]     prev;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]       count;
  logic [LT_W-1:0]        total;
  logic [LCNT_W-1:0]      lcnt;
  logic [VALUE_W-1:0]     lv;
  logic                   lempty;

  logic [PIXEL_W-1:0]     base [4];
  logic [PIXEL_W-1:0]     tap [5];
  logic                   take_en;
  logic                   has_prev;
  logic [PIXEL_W-1:0]     med;
  logic signed [PIXEL_W:0] diff;
  logic [PIXEL_W:0]       diff_abs;
  logic                   counted;
  logic [SUM_W-1:0]       sum_abs;
  logic [MAG_W-1:0]       sum_mag;

  logic                   div_start;
  logic [DIV_W-1:0]       div_hi;
  logic [VALUE_W-1:0]     div_lo;
  logic [DIV_W-1:0]       div_dvs;
  logic                   div_busy;
  logic [VALUE_W-1:0]     div_q;

  // Window taps for the median; the left edge is replicated on the first pixel.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      base[i] = (seen == 3'd0) ? pix_in : window[i];
    end
    tap[0]   = window[0];
    tap[1]   = window[1];
    tap[2]   = window[2];
    tap[3]   = window[3];
    tap[4]   = window[3];
    take_en  = 1'b0;
    has_prev = 1'b0;
    unique case (cmd.op)
      OP_STEP: begin
        tap[0]   = base[0];
        tap[1]   = base[1];
        tap[2]   = base[2];
        tap[3]   = base[3];
        tap[4]   = pix_in;
        take_en  = (seen >= 3'd2);
        has_prev = (seen >= 3'd3);
      end
      OP_FLUSH1: begin
        take_en  = (seen >= 3'd2);
        has_prev = (seen >= 3'd3);
      end
      OP_FLUSH2: begin
        tap[0]   = window[1];
        tap[1]   = window[2];
        tap[2]   = window[3];
        tap[3]   = window[3];
        take_en  = 1'b1;
        has_prev = (seen >= 3'd2);
      end
      default: begin
      end
    endcase
  end

  // Median, difference to the previous filtered pixel and the smoothness test.
  always_comb begin
    med      = median5(tap[0], tap[1], tap[2], tap[3], tap[4]);
    diff     = $signed({1'b0, prev}) - $signed({1'b0, med});
    diff_abs = diff[PIXEL_W] ? 9'(-diff) : 9'(diff);
    counted  = take_en && has_prev && (diff_abs < thr) &&
               (count < CNT_W'(MAX_LINE_PIXELS - 1));
    sum_abs  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    sum_mag  = sum_abs[MAG_W-1:0];
  end

  // Operands of the shared divider: line mean first, then image mean.
  always_comb begin
    div_start = (cmd.op == OP_LINE_DIV) || (cmd.op == OP_IMAGE_DIV);
    if (cmd.op == OP_IMAGE_DIV) begin
      div_hi  = DIV_W'(total[LT_W-1:VALUE_W]);
      div_lo  = total[VALUE_W-1:0];
      div_dvs = DIV_W'(lcnt);
    end else begin
      div_hi  = DIV_W'(sum_mag[MAG_W-1:8]);
      div_lo  = {sum_mag[7:0], 8'h00};
      div_dvs = DIV_W'(count);
    end
  end

  sigu_divider #(
    .DIV_W (DIV_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .hi       (div_hi),
    .lo       (div_lo),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Line and image state.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr   <= THRESH_RESET;
      seen  <= '0;
      prev  <= '0;
      sum   <= '0;
      count <= '0;
      total <= '0;
      lcnt  <= '0;
      for (int i = 0; i < 4; i++) begin
        window[i] <= '0;
      end
    end else begin
      if (cmd.cfg_write) begin
        thr <= diff_threshold;
      end
      if (take_en) begin
        prev <= med;
      end
      if (counted) begin
        sum   <= sum + SUM_W'(diff);
        count <= count + 1'b1;
      end
      unique case (cmd.op)
        OP_STEP: begin
          window[0] <= base[1];
          window[1] <= base[2];
          window[2] <= base[3];
          window[3] <= pix_in;
          if (seen < SEEN_FULL) begin
            seen <= seen + 3'd1;
          end
        end
        OP_ACCUM: begin
          if ((count != '0) && (lcnt < LCNT_W'(MAX_SCAN_LINES))) begin
            total <= total + LT_W'(div_q);
            lcnt  <= lcnt + 1'b1;
          end
        end
        OP_EMIT: begin
          seen  <= '0;
          prev  <= '0;
          sum   <= '0;
          count <= '0;
          for (int i = 0; i < 4; i++) begin
            window[i] <= '0;
          end
          if (eoi_in) begin
            total <= '0;
            lcnt  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Captured input transaction, line result and output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_in <= pixel;
      eol_in <= last_in_line;
      eoi_in <= last_in_image;
    end
    if (cmd.op == OP_ACCUM) begin
      lempty <= (count == '0);
      lv     <= (count == '0) ? '0 : div_q;
    end
    if (cmd.op == OP_EMIT) begin
      line_value  <= lv;
      line_empty  <= lempty;
      image_value <= (lcnt == '0) ? '0 : div_q;
      image_done  <= eoi_in;
    end
  end

  assign status.eol      = eol_in;
  assign status.div_busy = div_busy;

endmodule

@@ hdl/sigu_controller.sv @@
`include "scanline_illumination_gradient_unit_defines.svh"

module sigu_controller
  import sigu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   in_accept;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Pixels are taken while idle or while a pixel inside the line is filtered.
  assign in_ready  = (state == ST_IDLE) || ((state == ST_STEP) && !status.eol);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.load       = in_accept;
    cmd.cfg_write  = cfg_valid;
    cmd.op         = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.op = OP_STEP;
        if (status.eol) begin
          state_next = ST_FLUSH1;
        end else if (!in_accept) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH1: begin
        cmd.op     = OP_FLUSH1;
        state_next = ST_FLUSH2;
      end
      ST_FLUSH2: begin
        cmd.op     = OP_FLUSH2;
        state_next = ST_LINE_DIV;
      end
      ST_LINE_DIV: begin
        cmd.op     = OP_LINE_DIV;
        state_next = ST_LINE_WAIT;
      end
      ST_LINE_WAIT: begin
        if (!status.div_busy) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.op     = OP_ACCUM;
        state_next = ST_IMAGE_DIV;
      end
      ST_IMAGE_DIV: begin
        cmd.op     = OP_IMAGE_DIV;
        state_next = ST_IMAGE_WAIT;
      end
      ST_IMAGE_WAIT: begin
        if (!status.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // The result is loaded once the output register is free.
        if (!out_valid || out_ready) begin
          cmd.op         = OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SIGU_ASSERT_SAME(a_emit_free, cmd.op == OP_EMIT, !out_valid || out_ready, "result overwrote a pending transaction")
  `SIGU_ASSERT_NEXT(a_div_started, state == ST_LINE_DIV || state == ST_IMAGE_DIV, status.div_busy, "divider did not start")
  `SIGU_ASSERT_NEXT(a_line_flush, state == ST_STEP && status.eol, state == ST_FLUSH1, "line end did not flush")
  `SIGU_ASSERT_SAME(a_no_accept_busy, in_accept && status.div_busy, 1'b0, "pixel taken during division")

endmodule

@@ hdl/scanline_illumination_gradient_unit.sv @@
// Scanline illumination gradient unit.
// Input channel (in_valid/in_ready): one grey pixel per transaction with
// last_in_line marking the final pixel of a scanline and last_in_image,
// taken only with last_in_line, marking the final scanline of the image.
// Output channel (out_valid/out_ready): one transaction per scanline with the
// mean smooth difference of the line in 8.8 fixed point, an empty flag, the
// running image mean and image_done on the closing line.
// Configuration channel (cfg_valid/cfg_ready): writes diff_threshold; it is
// always ready. The user must see that it is written only while no line is in
// progress; the block itself does not enforce this.
// Throughput: pixels inside a line are taken one per cycle. After a line's
// last pixel the input stalls for two flush steps of the median window, then
// two 16-step runs of the shared restoring divider, one for the line mean and
// one for the image mean, before the result reaches the output register.
// A waiting result does not block the next line's pixels; only the next line
// end waits until the receiver takes the pending result.
// Reset (rst, synchronous) clears the window, the line and image totals and
// the output valid flag, and sets diff_threshold to 10.
module scanline_illumination_gradient_unit
  import sigu_pkg::*;
#(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int MAX_SCAN_LINES  = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIXEL_W-1:0]  pixel,
  input  logic                last_in_line,
  input  logic                last_in_image,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VALUE_W-1:0]  line_value,
  output logic                line_empty,
  output logic [VALUE_W-1:0]  image_value,
  output logic                image_done,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [THRESH_W-1:0] diff_threshold
);

  cmd_t    cmd;
  status_t status;

  // Sequencer for pixel steps, line flush, divisions and result hand-off.
  sigu_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Median filter, difference accumulation, divider and output register.
  sigu_datapath #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
    .MAX_SCAN_LINES  (MAX_SCAN_LINES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .diff_threshold (diff_threshold),
    .pixel          (pixel),
    .last_in_line   (last_in_line),
    .last_in_image  (last_in_image),
    .line_value     (line_value),
    .line_empty     (line_empty),
    .image_value    (image_value),
    .image_done     (image_done)
  );

endmodule
